[src/tks_pkg.sv]
// shared types and constants of the streaming top-k selector
// no dependencies; imported by tks_cell and top_k_streaming_selector
package tks_pkg;

    localparam int KEY_W        = 10;
    localparam int VAL_W        = 64;
    localparam int RANK_W       = 4;
    localparam int S_TDATA_W    = 80;
    localparam int M_TDATA_W    = 80;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam int TOP_K_DEF    = 10;
    localparam int NUM_KEYS_DEF = 1024;

    // register index of rank_mode
    localparam logic REG_RANK_MODE = 1'b0;

    typedef enum logic {
        OP_OFFER = 1'b0,
        OP_DUMP  = 1'b1
    } t_op;

    // broadcast to every cell of the row
    typedef struct packed {
        logic ins;   // insert the new entry at its sorted place
        logic pop;   // shift the row up by one towards cell 0
    } t_cell_ctl;

endpackage

[src/tks_cell.sv]
// one cell of the sorted row: holds one (key, value) entry
// depends on tks_pkg; instantiated in a chain by top_k_streaming_selector
module tks_cell
    import tks_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic             i_occ,
    input  logic [KEY_W-1:0] i_new_key,
    input  logic [VAL_W-1:0] i_new_val,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [VAL_W-1:0] i_prev_val,
    input  logic             i_prev_gt,
    input  logic [KEY_W-1:0] i_next_key,
    input  logic [VAL_W-1:0] i_next_val,
    output logic [KEY_W-1:0] o_key,
    output logic [VAL_W-1:0] o_val,
    output logic             o_gt
);

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // an empty cell always lies below the new entry; ties stay above it
    assign o_gt  = !i_occ || (i_new_val > r_val);
    assign o_key = r_key;
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_key <= i_next_key;
            r_val <= i_next_val;
        end else if (i_ctl.ins && o_gt) begin
            if (i_prev_gt) begin
                r_key <= i_prev_key;
                r_val <= i_prev_val;
            end else begin
                r_key <= i_new_key;
                r_val <= i_new_val;
            end
        end
    end

endmodule

[src/top_k_streaming_selector.sv]
// an offer passes through the count memory read, growth and row insert; a dump sends
// one beat per held entry (one for an empty list) and stalls under output back-pressure
// a new beat is accepted only in idle, once the previous offer or dump is through
// reset (synchronous, active low) empties the list, clears rank_mode, then sweeps the
// count memory to zero, one entry a cycle, with tready low
// depends on tks_pkg and tks_cell
module top_k_streaming_selector
    import tks_pkg::*;
#(
    parameter int TOP_K    = TOP_K_DEF,
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave beat
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // key[9:0], value[73:10], zero fill
    input  logic [0:0]            i_s_axis_tuser,   // op[0]
    // master beat
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // rank[3:0], key_res[13:4],
                                                    // ranked_value[77:14], zero fill
    output logic [0:0]            o_m_axis_tuser,   // is_empty[0]
    output logic                  o_m_axis_tlast,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW   = $clog2(NUM_KEYS);
    localparam int FW   = $clog2(TOP_K + 1);
    localparam int KR_W = 17;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_GROW,
        S_INS,
        S_DUMP
    } t_state;

    t_state r_state;

    logic [AW-1:0]     r_clr_addr;
    logic [FW-1:0]     r_fill;
    logic              r_mode;
    logic [RANK_W-1:0] r_rank;
    logic [KEY_W-1:0]  r_op_key;
    logic [VAL_W-1:0]  r_op_val;
    logic [VAL_W-1:0]  r_new_val;
    logic [VAL_W-1:0]  r_prev;
    logic [VAL_W-1:0]  mem [NUM_KEYS];

    logic              r_m_valid;
    logic [RANK_W-1:0] r_m_rank;
    logic [KEY_W-1:0]  r_m_key;
    logic [VAL_W-1:0]  r_m_val;
    logic              r_m_empty;
    logic              r_m_last;

    logic [KEY_W-1:0]  in_key;
    logic [VAL_W-1:0]  in_val;
    t_op               in_op;
    logic              s_accept;
    logic              key_ok;
    logic              cfg_wr;
    logic              out_free;
    logic [VAL_W-1:0]  ranked;
    t_cell_ctl         ctl;

    logic [KEY_W-1:0]  c_key [TOP_K];
    logic [VAL_W-1:0]  c_val [TOP_K];
    logic              c_gt  [TOP_K];

    assign in_key   = i_s_axis_tdata[KEY_W-1:0];
    assign in_val   = i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    assign in_op    = t_op'(i_s_axis_tuser[0]);
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign key_ok   = KR_W'(in_key) < KR_W'(NUM_KEYS);
    assign out_free = !r_m_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-RANK_W-KEY_W-VAL_W){1'b0}}, r_m_val, r_m_key, r_m_rank};
    assign o_m_axis_tuser  = r_m_empty;
    assign o_m_axis_tlast  = r_m_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RANK_MODE);
    assign prdata = (paddr[2] == REG_RANK_MODE) ? {{(APB_DATA_W-1){1'b0}}, r_mode}
                                                : '0;

    // in rank mode the growth over the previous count, saturating at zero; else the value itself
    always_comb begin
        if (!r_mode) begin
            ranked = r_op_val;
        end else if (r_op_val > r_prev) begin
            ranked = r_op_val - r_prev;
        end else begin
            ranked = '0;
        end
    end

    assign ctl = '{ins: (r_state == S_INS) && (r_new_val != '0),
                   pop: (r_state == S_DUMP) && out_free && (r_fill != '0)};

    // count memory: previous count per key, swept to zero in the clear state, written in rank mode
    always_ff @(posedge i_clk) begin
        r_prev <= mem[AW'(in_key)];
        if (r_state == S_CLEAR) begin
            mem[r_clr_addr] <= '0;
        end else if (r_state == S_GROW && r_mode) begin
            mem[AW'(r_op_key)] <= r_op_val;
        end
    end

    // the sorted row, cell 0 holds the largest
    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
        logic [KEY_W-1:0] prev_key;
        logic [VAL_W-1:0] prev_val;
        logic             prev_gt;
        logic [KEY_W-1:0] next_key;
        logic [VAL_W-1:0] next_val;

        if (i == 0) begin : g_head
            assign prev_key = '0;
            assign prev_val = '0;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_key = c_key[i-1];
            assign prev_val = c_val[i-1];
            assign prev_gt  = c_gt[i-1];
        end

        if (i == TOP_K - 1) begin : g_tail
            assign next_key = c_key[i];
            assign next_val = c_val[i];
        end else begin : g_inner
            assign next_key = c_key[i+1];
            assign next_val = c_val[i+1];
        end

        tks_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_occ      (FW'(i) < r_fill),
            .i_new_key  (r_op_key),
            .i_new_val  (r_new_val),
            .i_prev_key (prev_key),
            .i_prev_val (prev_val),
            .i_prev_gt  (prev_gt),
            .i_next_key (next_key),
            .i_next_val (next_val),
            .o_key      (c_key[i]),
            .o_val      (c_val[i]),
            .o_gt       (c_gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_fill     <= '0;
            r_mode     <= 1'b0;
            r_rank     <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_mode <= pwdata[0];
            end
            // a new row loaded in the dump state takes the place of the one leaving
            if (r_m_valid && i_m_axis_tready && !(r_state == S_DUMP && out_free)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(NUM_KEYS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_op_key <= in_key;
                        r_op_val <= in_val;
                        if (in_op == OP_DUMP) begin
                            r_rank  <= '0;
                            r_state <= S_DUMP;
                        end else if (key_ok) begin
                            r_state <= S_GROW;
                        end
                    end
                end
                S_GROW: begin
                    r_new_val <= ranked;
                    r_state   <= S_INS;
                end
                S_INS: begin
                    if (r_new_val != '0 && r_fill < FW'(TOP_K)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_DUMP: begin
                    if (out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_rank  <= r_rank;
                        r_m_empty <= (r_fill == '0);
                        r_m_last  <= (r_fill <= FW'(1));
                        r_m_key   <= (r_fill == '0) ? '0 : c_key[0];
                        r_m_val   <= (r_fill == '0) ? '0 : c_val[0];
                        r_rank    <= r_rank + 1'b1;
                        if (r_fill <= FW'(1)) begin
                            r_fill  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_fill <= r_fill - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
